// ===== rtl/mrlp_pkg.sv =====
// Shared types and constants for the multi-radix literal parser.
// Used by every module in rtl/; no dependencies.
package mrlp_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned DIGIT_W    = 9;   // signed digit: -48 .. 255
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_CASE_OFS  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_LOWER_X   = 8'h78;
  localparam logic [DIGIT_W-1:0] HEX_ALPHA_OFS = 9'd87; // 'a' - 10

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR = 3'd0,
    KIND_DEC  = 3'd1,
    KIND_REAL = 3'd2,
    KIND_HEX  = 3'd3,
    KIND_BIN  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_MAC10 = 3'd2,
    OP_MAC16 = 3'd3,
    OP_MAC2  = 3'd4
  } op_e;

  // One classified character, front to back.
  typedef struct packed {
    op_e                       op;
    logic signed [DIGIT_W-1:0] digit;
    logic                      clear;     // token start: drop accumulator first
    logic                      last;      // emit result after this update
    logic                      zero_out;  // kind without a value
  } cmd_t;

endpackage

// ===== rtl/mrlp_front.sv =====
// Front end: tracks character position and the real-literal stop flag,
// turns each character into an accumulate command. Depends on mrlp_pkg.
module mrlp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [mrlp_pkg::CHAR_W-1:0]  char_i,
  input  logic [mrlp_pkg::KIND_W-1:0]  kind_i,
  input  logic                         first_i,
  input  logic                         last_i,
  output mrlp_pkg::cmd_t               cmd_o
);
  import mrlp_pkg::*;

  logic [1:0] pos_q, pos_d, pos_cur;
  logic       stop_q, stop_d, stop_cur, stop_new;
  logic [CHAR_W-1:0] lower_c;

  assign pos_cur  = first_i ? 2'd0 : pos_q;
  assign stop_cur = first_i ? 1'b0 : stop_q;

  assign lower_c = (char_i >= CH_UPPER_A && char_i <= CH_UPPER_Z) ?
                   char_i + CH_CASE_OFS : char_i;

  always_comb begin
    cmd_o.op       = OP_NONE;
    cmd_o.digit    = {1'b0, char_i} - {1'b0, CH_ZERO};
    cmd_o.clear    = first_i;
    cmd_o.last     = last_i;
    cmd_o.zero_out = 1'b1;
    stop_new       = stop_cur;
    case (kind_e'(kind_i))
      KIND_CHAR: begin
        cmd_o.zero_out = 1'b0;
        cmd_o.digit    = (char_i == CH_BACKSLASH) ? '0 : {1'b0, char_i};
        if (pos_cur == 2'd1) begin
          cmd_o.op = OP_LOAD;
        end
      end
      KIND_DEC: begin
        cmd_o.zero_out = 1'b0;
        cmd_o.op       = OP_MAC10;
      end
      KIND_REAL: begin
        cmd_o.zero_out = 1'b0;
        if (!stop_cur) begin
          if (char_i >= CH_ZERO && char_i <= CH_NINE) begin
            cmd_o.op = OP_MAC10;
          end else begin
            stop_new = 1'b1;
          end
        end
      end
      KIND_HEX: begin
        cmd_o.zero_out = 1'b0;
        if (char_i > CH_NINE) begin
          cmd_o.digit = {1'b0, lower_c} - HEX_ALPHA_OFS;
        end
        if (!(pos_cur == 2'd0 || (pos_cur == 2'd1 && char_i == CH_LOWER_X))) begin
          cmd_o.op = OP_MAC16;
        end
      end
      KIND_BIN: begin
        cmd_o.zero_out = 1'b0;
        if (pos_cur != 2'd0) begin
          cmd_o.op = OP_MAC2;
        end
      end
      default: begin
        cmd_o.op = OP_NONE;
      end
    endcase
  end

  always_comb begin
    pos_d  = pos_q;
    stop_d = stop_q;
    if (push_i) begin
      if (last_i) begin
        pos_d  = 2'd0;
        stop_d = 1'b0;
      end else begin
        pos_d  = (pos_cur == 2'd3) ? 2'd3 : pos_cur + 2'd1;
        stop_d = stop_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      stop_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      stop_q <= stop_d;
    end
  end

endmodule

// ===== rtl/mrlp_fifo.sv =====
// Short command queue between front and back ends.
// Depends on mrlp_pkg for the command type.
module mrlp_fifo #(
  parameter int unsigned Depth = mrlp_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mrlp_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mrlp_pkg::cmd_t head_o
);
  import mrlp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/mrlp_back.sv =====
// Back end: 64-bit shift-add accumulator and the result output register.
// Depends on mrlp_pkg.
module mrlp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  mrlp_pkg::cmd_t                 cmd_i,
  output logic                           cmd_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mrlp_pkg::VALUE_W-1:0]   out_value_o
);
  import mrlp_pkg::*;

  logic [VALUE_W-1:0] acc_q, acc_d, base, upd, dig_ext;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q;

  assign base    = cmd_i.clear ? '0 : acc_q;
  assign dig_ext = {{(VALUE_W-DIGIT_W){cmd_i.digit[DIGIT_W-1]}}, cmd_i.digit};

  always_comb begin
    case (cmd_i.op)
      OP_LOAD:  upd = dig_ext;
      OP_MAC10: upd = {base[VALUE_W-4:0], 3'b000} + {base[VALUE_W-2:0], 1'b0} + dig_ext;
      OP_MAC16: upd = {base[VALUE_W-5:0], 4'b0000} + dig_ext;
      OP_MAC2:  upd = {base[VALUE_W-2:0], 1'b0} + dig_ext;
      default:  upd = base;
    endcase
  end

  // A final character stalls only while an unread result sits in the register.
  assign cmd_pop_o = cmd_valid_i && (!cmd_i.last || !out_valid_q || out_ready_i);

  always_comb begin
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_pop_o) begin
      acc_d = cmd_i.last ? '0 : upd;
      if (cmd_i.last) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.last) begin
      out_value_q <= cmd_i.zero_out ? '0 : upd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;

endmodule

// ===== rtl/multi_radix_literal_parser.sv =====
// Multi-radix assembler literal parser, one character per request.
// The request carrying tlast is queued, then its result is registered.
// Throughput: one character per cycle while the queue is not full; the 64-bit
// shift-add in the back end sets this rate.
// Reset (rst_ni, async, active low) clears the accumulator, position,
// real-literal stop flag, queue pointers and output valid.
module multi_radix_literal_parser #(
  parameter int unsigned FifoDepth = mrlp_pkg::FIFO_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [7:0] char_in
  input  logic [3:0]                   s_axis_tuser_i,  // [2:0] token_kind, [3] first_char
  input  logic                         s_axis_tlast_i,  // last_char
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [63:0]                  m_axis_tdata_o   // [63:0] value
);
  import mrlp_pkg::*;

  logic in_accept;
  logic q_full, q_valid, q_pop;
  cmd_t front_cmd, back_cmd;

  // The front end never stalls on the back end directly; only a full queue
  // holds off new characters.
  assign s_axis_tready_o = !q_full;
  assign in_accept       = s_axis_tvalid_i && !q_full;

  mrlp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .char_i  (s_axis_tdata_i),
    .kind_i  (s_axis_tuser_i[KIND_W-1:0]),
    .first_i (s_axis_tuser_i[KIND_W]),
    .last_i  (s_axis_tlast_i),
    .cmd_o   (front_cmd)
  );

  mrlp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (back_cmd)
  );

  // Back end updates the accumulator and holds finished values in its
  // output register until the sink takes them.
  mrlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_value_o (m_axis_tdata_o)
  );

endmodule
